// ===== hw/rtl/mhfp_pkg.sv =====
// Package for the message header field parser: phase codes, result kinds,
// character constants, word types and byte class functions.
// Depends on nothing; all files but mhfp_if import it.
`default_nettype none

package mhfp_pkg;

    localparam logic [3:0] PH_FIELD_START = 4'd0;
    localparam logic [3:0] PH_NAME        = 4'd1;
    localparam logic [3:0] PH_VAL_START   = 4'd2;
    localparam logic [3:0] PH_VAL_CR      = 4'd3;
    localparam logic [3:0] PH_VAL_LINE    = 4'd4;
    localparam logic [3:0] PH_VAL_LINE_CR = 4'd5;
    localparam logic [3:0] PH_VAL_FOLD    = 4'd6;
    localparam logic [3:0] PH_VAL_TEXT    = 4'd7;
    localparam logic [3:0] PH_END_BLANK   = 4'd8;
    localparam logic [3:0] PH_END_CR      = 4'd9;
    localparam logic [3:0] PH_BODY        = 4'd10;
    localparam logic [3:0] PH_FAILED      = 4'd11;

    localparam logic [2:0] KIND_NAME       = 3'd0;
    localparam logic [2:0] KIND_VALUE      = 3'd1;
    localparam logic [2:0] KIND_FIELD_END  = 3'd2;
    localparam logic [2:0] KIND_HEADER_END = 3'd3;
    localparam logic [2:0] KIND_BODY       = 3'd4;
    localparam logic [2:0] KIND_OK         = 3'd5;
    localparam logic [2:0] KIND_ERROR      = 3'd6;

    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_VIS_LO    = 8'h21;
    localparam logic [7:0] CH_NAME_A_HI = 8'h39;
    localparam logic [7:0] CH_NAME_B_LO = 8'h3B;
    localparam logic [7:0] CH_NAME_B_HI = 8'h7E;
    localparam logic [7:0] CH_VIS_HI    = 8'hFF;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_LOWER_Z   = 8'h7A;
    localparam logic [7:0] CASE_UP_MASK = 8'hDF;
    localparam logic [7:0] CASE_LO_BIT  = 8'h20;
    localparam logic [7:0] ZERO_BYTE    = 8'h00;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] kind;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic logic is_name_byte(input logic [7:0] c);
        return ((c >= CH_VIS_LO) && (c <= CH_NAME_A_HI)) ||
               ((c >= CH_NAME_B_LO) && (c <= CH_NAME_B_HI));
    endfunction

    function automatic logic is_visible(input logic [7:0] c);
        return (c >= CH_VIS_LO) && (c <= CH_VIS_HI);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
               ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
    endfunction

    function automatic logic [7:0] fix_case(input logic [7:0] c, input logic upper);
        logic [7:0] r;
        r = c;
        if (is_letter(c))
        begin
            r = upper ? (c & CASE_UP_MASK) : (c | CASE_LO_BIT);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mhfp_if.sv =====
// Stream interfaces of the message header field parser: the byte input
// channel and the result output channel, each with valid and ready.
// Depends on nothing.
`default_nettype none

interface mhfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;
    logic       end_of_message;

    modport source (output valid, output data, output end_of_message, input ready);
    modport sink (input valid, input data, input end_of_message, output ready);
endinterface

interface mhfp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [2:0] kind;
    logic       last;

    modport source (output valid, output out_byte, output kind, output last, input ready);
    modport sink (input valid, input out_byte, input kind, input last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/message_header_field_parser.sv =====
// Top level of the message header field parser: parser stage and result queue.
// Depends on mhfp_pkg, mhfp_if, mhfp_parser and mhfp_result_fifo.
//
// The in_stream channel carries one message byte per word, or an end of
// message marker. The out_stream channel carries one result per word: a name
// byte in normalized case, a value byte, a field end, a header end, a body
// byte, or the ok or error status at the end of the message; last marks the
// final result caused by an input word.
// A word accepted from in_stream waits in the input register until the
// result queue has room; it is then parsed and its results are written to
// the queue. One input word is taken per cycle while each word causes at
// most one result and out_stream does not stall; a word that causes two
// results leaves the single read port of the four-entry result queue one
// result at a time, setting the sustained rate; no-result words use no entry.
// When out_stream stalls, the queue fills; the parser waits once fewer than
// two entries are free, and in_stream ready falls after the input register
// is also full. Nothing is dropped.
// Reset clears the queue, the input register and the parser state to the
// start of a new message. An end of message marker also returns the parser
// to that start state.
`default_nettype none

module message_header_field_parser (
    input  logic       clk,
    input  logic       rst_n,
    mhfp_in_if.sink    in_stream,
    mhfp_out_if.source out_stream
);
    import mhfp_pkg::*;

    push_t push;
    logic  room;

    mhfp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_stream (in_stream),
        .room      (room),
        .push      (push)
    );

    mhfp_result_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room       (room),
        .out_stream (out_stream)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/mhfp_parser.sv =====
// Input register and parse logic: holds one input word, advances the
// header grammar state and produces up to two results per word.
// Depends on mhfp_pkg and mhfp_if.
`default_nettype none

module mhfp_parser (
    input  logic            clk,
    input  logic            rst_n,
    mhfp_in_if.sink         in_stream,
    input  logic            room,
    output mhfp_pkg::push_t push
);
    import mhfp_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_data_reg;
    logic       in_eom_reg;
    logic [3:0] phase_reg;
    logic [3:0] phase_next;
    logic       cap_reg;
    logic       cap_next;
    logic       nonempty_reg;
    logic       nonempty_next;
    logic       fire;
    logic       take;

    logic [3:0] fs_phase;
    logic       fs_cap;
    logic       fs_put;
    logic [7:0] fs_byte;
    logic [2:0] fs_kind;

    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [2:0] k0;
    logic [2:0] k1;

    assign fire = in_valid_reg && room;
    assign in_stream.ready = !in_valid_reg || room;
    assign take = in_stream.valid && in_stream.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_data_reg <= in_stream.data;
            in_eom_reg  <= in_stream.end_of_message;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_FIELD_START;
            cap_reg      <= 1'b1;
            nonempty_reg <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg    <= phase_next;
            cap_reg      <= cap_next;
            nonempty_reg <= nonempty_next;
        end
    end

    // The first byte of a line that may start a field or end the header.
    always_comb
    begin
        fs_put  = 1'b0;
        fs_byte = ZERO_BYTE;
        fs_kind = KIND_NAME;
        fs_cap  = 1'b1;
        priority if (is_name_byte(in_data_reg))
        begin
            fs_put   = 1'b1;
            fs_byte  = fix_case(in_data_reg, 1'b1);
            fs_cap   = !is_letter(in_data_reg);
            fs_phase = PH_NAME;
        end
        else if (is_blank(in_data_reg))
        begin
            fs_phase = PH_END_BLANK;
        end
        else if (in_data_reg == CH_CR)
        begin
            fs_phase = PH_END_CR;
        end
        else if (in_data_reg == CH_LF)
        begin
            fs_put   = 1'b1;
            fs_kind  = KIND_HEADER_END;
            fs_phase = PH_BODY;
        end
        else
        begin
            fs_phase = PH_FAILED;
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        cap_next      = cap_reg;
        nonempty_next = nonempty_reg;
        cnt = 2'd0;
        b0  = ZERO_BYTE;
        b1  = ZERO_BYTE;
        k0  = KIND_NAME;
        k1  = KIND_NAME;
        if (in_eom_reg)
        begin
            cnt = 2'd1;
            k0  = (phase_reg == PH_BODY) ? KIND_OK : KIND_ERROR;
            phase_next    = PH_FIELD_START;
            cap_next      = 1'b1;
            nonempty_next = 1'b0;
        end
        else
        begin
            unique case (phase_reg)
                PH_FIELD_START:
                begin
                    phase_next    = fs_phase;
                    cap_next      = fs_cap;
                    nonempty_next = 1'b0;
                    if (fs_put)
                    begin
                        cnt = 2'd1;
                        b0  = fs_byte;
                        k0  = fs_kind;
                    end
                end
                PH_NAME:
                begin
                    priority if (is_name_byte(in_data_reg))
                    begin
                        cnt = 2'd1;
                        b0  = fix_case(in_data_reg, cap_reg);
                        k0  = KIND_NAME;
                        cap_next = !is_letter(in_data_reg);
                    end
                    else if (in_data_reg == CH_COLON)
                    begin
                        phase_next = PH_VAL_START;
                    end
                    else
                    begin
                        phase_next = PH_FAILED;
                    end
                end
                PH_VAL_START, PH_VAL_TEXT:
                begin
                    priority if (is_blank(in_data_reg) && (phase_reg == PH_VAL_START))
                    begin
                        phase_next = phase_reg;
                    end
                    else if (is_visible(in_data_reg) || is_blank(in_data_reg))
                    begin
                        cnt = 2'd1;
                        b0  = in_data_reg;
                        k0  = KIND_VALUE;
                        nonempty_next = 1'b1;
                        phase_next    = PH_VAL_TEXT;
                    end
                    else if (in_data_reg == CH_CR)
                    begin
                        phase_next = PH_VAL_CR;
                    end
                    else if (in_data_reg == CH_LF)
                    begin
                        phase_next = PH_VAL_LINE;
                    end
                    else
                    begin
                        phase_next = PH_FAILED;
                    end
                end
                PH_VAL_CR:
                begin
                    phase_next = (in_data_reg == CH_LF) ? PH_VAL_LINE : PH_FAILED;
                end
                PH_VAL_LINE:
                begin
                    priority if (is_blank(in_data_reg))
                    begin
                        phase_next = PH_VAL_FOLD;
                    end
                    else if (in_data_reg == CH_CR)
                    begin
                        phase_next = PH_VAL_LINE_CR;
                    end
                    else
                    begin
                        cnt = fs_put ? 2'd2 : 2'd1;
                        k0  = KIND_FIELD_END;
                        b1  = fs_byte;
                        k1  = fs_kind;
                        phase_next    = fs_phase;
                        cap_next      = fs_cap;
                        nonempty_next = 1'b0;
                    end
                end
                PH_VAL_LINE_CR, PH_VAL_FOLD:
                begin
                    priority if (is_blank(in_data_reg) && (phase_reg == PH_VAL_FOLD))
                    begin
                        phase_next = phase_reg;
                    end
                    else if (is_visible(in_data_reg) && (phase_reg == PH_VAL_FOLD))
                    begin
                        // A folded line is joined to a nonempty value by one space.
                        if (nonempty_reg)
                        begin
                            cnt = 2'd2;
                            b0  = CH_SPACE;
                            k0  = KIND_VALUE;
                            b1  = in_data_reg;
                            k1  = KIND_VALUE;
                        end
                        else
                        begin
                            cnt = 2'd1;
                            b0  = in_data_reg;
                            k0  = KIND_VALUE;
                        end
                        nonempty_next = 1'b1;
                        phase_next    = PH_VAL_TEXT;
                    end
                    else if ((in_data_reg == CH_CR) && (phase_reg == PH_VAL_FOLD))
                    begin
                        phase_next = PH_VAL_LINE_CR;
                    end
                    else if (in_data_reg == CH_LF)
                    begin
                        cnt = 2'd2;
                        k0  = KIND_FIELD_END;
                        k1  = KIND_HEADER_END;
                        phase_next = PH_BODY;
                    end
                    else
                    begin
                        phase_next = PH_FAILED;
                    end
                end
                PH_END_BLANK, PH_END_CR:
                begin
                    priority if (is_blank(in_data_reg) && (phase_reg == PH_END_BLANK))
                    begin
                        phase_next = phase_reg;
                    end
                    else if (in_data_reg == CH_LF)
                    begin
                        cnt = 2'd1;
                        k0  = KIND_HEADER_END;
                        phase_next = PH_BODY;
                    end
                    else if ((in_data_reg == CH_CR) && (phase_reg == PH_END_BLANK))
                    begin
                        phase_next = PH_END_CR;
                    end
                    else
                    begin
                        phase_next = PH_FAILED;
                    end
                end
                PH_BODY:
                begin
                    cnt = 2'd1;
                    b0  = in_data_reg;
                    k0  = KIND_BODY;
                end
                default:
                begin
                    phase_next = PH_FAILED;
                end
            endcase
        end
    end

    assign push.count         = fire ? cnt : 2'd0;
    assign push.first.out_byte  = b0;
    assign push.first.kind      = k0;
    assign push.first.last      = (cnt == 2'd1);
    assign push.second.out_byte = b1;
    assign push.second.kind     = k1;
    assign push.second.last     = 1'b1;

endmodule

`default_nettype wire

// ===== hw/rtl/mhfp_result_fifo.sv =====
// Four-entry result queue: takes up to two results per cycle from the
// parser and presents one word per cycle on the output channel while it is ready.
// Depends on mhfp_pkg and mhfp_if.
`default_nettype none

module mhfp_result_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  mhfp_pkg::push_t push,
    output logic            room,
    mhfp_out_if.source      out_stream
);
    import mhfp_pkg::*;

    result_t    entry_reg [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] count_reg;
    logic       pop;
    logic [1:0] wr_ptr_plus;

    assign room = (count_reg <= 3'd2);
    assign pop  = out_stream.valid && out_stream.ready;
    assign wr_ptr_plus = wr_ptr_reg + 2'd1;

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[wr_ptr_plus] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + push.count;
            rd_ptr_reg <= rd_ptr_reg + {1'b0, pop};
            count_reg  <= count_reg + {1'b0, push.count} - {2'b00, pop};
        end
    end

    assign out_stream.valid    = (count_reg != 3'd0);
    assign out_stream.out_byte = entry_reg[rd_ptr_reg].out_byte;
    assign out_stream.kind     = entry_reg[rd_ptr_reg].kind;
    assign out_stream.last     = entry_reg[rd_ptr_reg].last;

endmodule

`default_nettype wire

// ===== hw/rtl/mhfp_checker.sv =====
// Port checker for the message header field parser, bound to the top level.
// Depends on mhfp_pkg and mhfp_if.
`default_nettype none

module mhfp_checker (
    input logic        clk,
    input logic        rst_n,
    mhfp_out_if.source out_stream
);
    import mhfp_pkg::*;

    property p_hold_valid;
        @(posedge clk) disable iff (!rst_n)
            out_stream.valid && !out_stream.ready |=> out_stream.valid;
    endproperty
    a_hold_valid: assert property (p_hold_valid)
        else $error("output word withdrawn while stalled");

    property p_status_last;
        @(posedge clk) disable iff (!rst_n)
            out_stream.valid && ((out_stream.kind == KIND_OK) ||
                                 (out_stream.kind == KIND_ERROR)) |-> out_stream.last;
    endproperty
    a_status_last: assert property (p_status_last)
        else $error("message status is not the final result");

    property p_marker_zero;
        @(posedge clk) disable iff (!rst_n)
            out_stream.valid && ((out_stream.kind == KIND_FIELD_END) ||
                                 (out_stream.kind == KIND_HEADER_END) ||
                                 (out_stream.kind == KIND_OK) ||
                                 (out_stream.kind == KIND_ERROR))
            |-> (out_stream.out_byte == ZERO_BYTE);
    endproperty
    a_marker_zero: assert property (p_marker_zero)
        else $error("marker word carries a nonzero byte");

    property p_field_end_pair;
        @(posedge clk) disable iff (!rst_n)
            out_stream.valid && out_stream.ready && out_stream.last &&
            (out_stream.kind == KIND_FIELD_END) ##1 out_stream.valid
            |-> (out_stream.kind != KIND_BODY);
    endproperty
    a_field_end_pair: assert property (p_field_end_pair)
        else $error("body byte directly after a field end");

endmodule

bind message_header_field_parser mhfp_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_stream (out_stream)
);

`default_nettype wire
